/* rtl/vrps_pkg.sv */
// ----------------------------------------------------------------------------
// Video register port package
// Shared command codes, register numbers, controller states and the
// command and status words that pass between controller and datapath.
// ----------------------------------------------------------------------------
package vrps_pkg;

   typedef enum logic [2:0] {
      CMD_WRITE      = 3'd0,
      CMD_READ       = 3'd1,
      CMD_COARSE_X   = 3'd2,
      CMD_INC_Y      = 3'd3,
      CMD_COPY_HORIZ = 3'd4,
      CMD_COPY_VERT  = 3'd5,
      CMD_VBLANK_SET = 3'd6,
      CMD_PRERENDER  = 3'd7
   } cmd_type;

   localparam logic [2:0] REG_CONTROL     = 3'd0;
   localparam logic [2:0] REG_MASK        = 3'd1;
   localparam logic [2:0] REG_STATUS      = 3'd2;
   localparam logic [2:0] REG_SPRITE_ADDR = 3'd3;
   localparam logic [2:0] REG_SPRITE_DATA = 3'd4;
   localparam logic [2:0] REG_SCROLL      = 3'd5;
   localparam logic [2:0] REG_ADDRESS     = 3'd6;
   localparam logic [2:0] REG_DATA        = 3'd7;

   localparam int SPRITE_MEM_BYTES = 256;
   localparam int TABLE_BYTES      = 1024;
   localparam int PALETTE_BYTES    = 32;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_LOAD = 3'b100
   } state_type;

   typedef enum logic [1:0] {
      RGN_NONE    = 2'd0,
      RGN_TABLE_A = 2'd1,
      RGN_TABLE_B = 2'd2,
      RGN_PALETTE = 2'd3
   } region_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic data_read;
   } dp_status_type;

endpackage

/* rtl/video_register_port_scroll_unit.sv */
// ----------------------------------------------------------------------------
// Video register port and scroll unit
// Bus register port of a tile video unit with scroll and address registers,
// read buffer, sprite memory, two name tables and a mirrored palette.
//
//   Channel   Ports                                    Handshake
//   request   req_command, req_reg_index,              start high, busy low
//             req_write_data
//   result    rsp_read_data, rsp_nmi_pulse,            rsp_valid, one cycle
//             rsp_vram_address, rsp_fine_scroll_x
//
// A word passes the execute state before its result strobe; a video data
// read also passes the load state, since the name table or palette read is
// registered. Busy is low in the cycle that shows the result, so a new word
// can start there. Reset clears the port and scroll registers, not the
// memories or the result registers. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module video_register_port_scroll_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [2:0]  req_reg_index,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_nmi_pulse,
   output logic [15:0] rsp_vram_address,
   output logic [2:0]  rsp_fine_scroll_x
);

   vrps_pkg::ctrl_cmd_type  cmd;
   vrps_pkg::dp_status_type status;

   vrps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   vrps_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_command       (req_command),
      .req_reg_index     (req_reg_index),
      .req_write_data    (req_write_data),
      .rsp_read_data     (rsp_read_data),
      .rsp_nmi_pulse     (rsp_nmi_pulse),
      .rsp_vram_address  (rsp_vram_address),
      .rsp_fine_scroll_x (rsp_fine_scroll_x)
   );

endmodule

/* rtl/vrps_ctrl.sv */
// ----------------------------------------------------------------------------
// Video register port controller
// Sequences one word through capture, execute and, for video data reads,
// a memory load state, and raises the result strobe.
// ----------------------------------------------------------------------------
module vrps_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_valid,
   output vrps_pkg::ctrl_cmd_type  cmd,
   input  vrps_pkg::dp_status_type status
);

   vrps_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;

   assign busy   = (state_ff != vrps_pkg::ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         vrps_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = vrps_pkg::ST_EXEC;
            end
         end
         vrps_pkg::ST_EXEC: begin
            if (status.data_read) begin
               state_in = vrps_pkg::ST_LOAD;
            end else begin
               state_in     = vrps_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         vrps_pkg::ST_LOAD: begin
            state_in     = vrps_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = vrps_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vrps_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = accept;
   assign cmd.execute = (state_ff == vrps_pkg::ST_EXEC);
   assign cmd.load    = (state_ff == vrps_pkg::ST_LOAD);

endmodule

/* rtl/vrps_datapath.sv */
// ----------------------------------------------------------------------------
// Video register port datapath
// Holds the register file, scroll registers, read buffer, sprite memory,
// both name tables and the palette, and forms each result word.
// ----------------------------------------------------------------------------
module vrps_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  vrps_pkg::ctrl_cmd_type  cmd,
   output vrps_pkg::dp_status_type status,
   input  logic [2:0]              req_command,
   input  logic [2:0]              req_reg_index,
   input  logic [7:0]              req_write_data,
   output logic [7:0]              rsp_read_data,
   output logic                    rsp_nmi_pulse,
   output logic [15:0]             rsp_vram_address,
   output logic [2:0]              rsp_fine_scroll_x
);

   localparam int SprAw = $clog2(vrps_pkg::SPRITE_MEM_BYTES);
   localparam int TabAw = $clog2(vrps_pkg::TABLE_BYTES);
   localparam int PalAw = $clog2(vrps_pkg::PALETTE_BYTES);

   vrps_pkg::cmd_type    cmd_ff;
   logic [2:0]           reg_ff;
   logic [7:0]           data_ff;

   logic [7:0]           control_ff, control_in;
   logic [7:0]           mask_ff, mask_in;
   logic [7:0]           status_ff, status_in;
   logic [7:0]           sprite_ptr_ff, sprite_ptr_in;
   logic [15:0]          v_ff, v_in;
   logic [15:0]          t_ff, t_in;
   logic [2:0]           fine_x_ff, fine_x_in;
   logic                 toggle_ff, toggle_in;
   logic [7:0]           buffer_ff, buffer_in;
   logic [7:0]           rd_ff, rd_in;
   logic                 nmi_ff, nmi_in;

   vrps_pkg::region_type region_ff, region_cur;
   logic                 high_ff;
   logic [PalAw-1:0]     pal_slot;
   logic [TabAw-1:0]     tab_idx;
   logic [7:0]           tab_a_rd_ff, tab_b_rd_ff, pal_rd_ff;
   logic [7:0]           fetched;
   logic                 vmem_we, sprite_we;
   logic                 rendering;
   logic [15:0]          step;
   logic [4:0]           coarse_y;
   logic                 y_flip;

   logic [7:0]           sprite_memory [vrps_pkg::SPRITE_MEM_BYTES];
   logic [7:0]           table_a [vrps_pkg::TABLE_BYTES];
   logic [7:0]           table_b [vrps_pkg::TABLE_BYTES];
   logic [7:0]           palette_mem [vrps_pkg::PALETTE_BYTES];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= vrps_pkg::cmd_type'(req_command);
         reg_ff  <= req_reg_index;
         data_ff <= req_write_data;
      end
   end

   assign status.data_read = (cmd_ff == vrps_pkg::CMD_READ) && (reg_ff == vrps_pkg::REG_DATA);

   always_comb begin
      if (v_ff[15:14] != 2'b00 || !v_ff[13]) begin
         region_cur = vrps_pkg::RGN_NONE;
      end else if (v_ff[12:8] == 5'h1F) begin
         region_cur = vrps_pkg::RGN_PALETTE;
      end else if (v_ff[11:10] == 2'b00) begin
         region_cur = vrps_pkg::RGN_TABLE_A;
      end else begin
         region_cur = vrps_pkg::RGN_TABLE_B;
      end
   end

   assign tab_idx  = v_ff[TabAw-1:0];
   assign pal_slot = (v_ff[1:0] == 2'b00) ? {1'b0, v_ff[PalAw-2:0]} : v_ff[PalAw-1:0];
   assign vmem_we  = cmd.execute && (cmd_ff == vrps_pkg::CMD_WRITE) &&
                     (reg_ff == vrps_pkg::REG_DATA);
   assign sprite_we = cmd.execute && (cmd_ff == vrps_pkg::CMD_WRITE) &&
                      (reg_ff == vrps_pkg::REG_SPRITE_DATA);

   always_ff @(posedge clock) begin
      if (sprite_we) begin
         sprite_memory[sprite_ptr_ff[SprAw-1:0]] <= data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (vmem_we && region_cur == vrps_pkg::RGN_TABLE_A) begin
         table_a[tab_idx] <= data_ff;
      end
      tab_a_rd_ff <= table_a[tab_idx];
   end

   always_ff @(posedge clock) begin
      if (vmem_we && region_cur == vrps_pkg::RGN_TABLE_B) begin
         table_b[tab_idx] <= data_ff;
      end
      tab_b_rd_ff <= table_b[tab_idx];
   end

   always_ff @(posedge clock) begin
      if (vmem_we && region_cur == vrps_pkg::RGN_PALETTE) begin
         palette_mem[pal_slot] <= data_ff;
      end
      pal_rd_ff <= palette_mem[pal_slot];
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         region_ff <= region_cur;
         high_ff   <= (v_ff >= 16'h3F00);
      end
   end

   always_comb begin
      case (region_ff)
         vrps_pkg::RGN_TABLE_A: fetched = tab_a_rd_ff;
         vrps_pkg::RGN_TABLE_B: fetched = tab_b_rd_ff;
         vrps_pkg::RGN_PALETTE: fetched = pal_rd_ff;
         default:               fetched = 8'd0;
      endcase
   end

   assign rendering = mask_ff[4] || mask_ff[3];
   assign step      = control_ff[2] ? 16'd32 : 16'd1;
   assign y_flip    = (v_ff[9:5] == 5'd29);

   always_comb begin
      if (v_ff[9:5] == 5'd29 || v_ff[9:5] == 5'd31) begin
         coarse_y = 5'd0;
      end else begin
         coarse_y = v_ff[9:5] + 5'd1;
      end
   end

   always_comb begin
      control_in    = control_ff;
      mask_in       = mask_ff;
      status_in     = status_ff;
      sprite_ptr_in = sprite_ptr_ff;
      v_in          = v_ff;
      t_in          = t_ff;
      fine_x_in     = fine_x_ff;
      toggle_in     = toggle_ff;
      buffer_in     = buffer_ff;
      rd_in         = rd_ff;
      nmi_in        = nmi_ff;
      if (cmd.execute) begin
         rd_in  = 8'd0;
         nmi_in = 1'b0;
         case (cmd_ff)
            vrps_pkg::CMD_WRITE: begin
               case (reg_ff)
                  vrps_pkg::REG_CONTROL: begin
                     nmi_in     = !control_ff[7] && data_ff[7] && status_ff[7];
                     control_in = data_ff;
                     t_in       = {t_ff[15:12], data_ff[1:0], t_ff[9:0]};
                  end
                  vrps_pkg::REG_MASK: begin
                     mask_in = data_ff;
                  end
                  vrps_pkg::REG_SPRITE_ADDR: begin
                     sprite_ptr_in = data_ff;
                  end
                  vrps_pkg::REG_SPRITE_DATA: begin
                     sprite_ptr_in = sprite_ptr_ff + 8'd1;
                  end
                  vrps_pkg::REG_SCROLL: begin
                     if (!toggle_ff) begin
                        fine_x_in = data_ff[2:0];
                        t_in      = {t_ff[15:5], data_ff[7:3]};
                        toggle_in = 1'b1;
                     end else begin
                        t_in      = {t_ff[15], data_ff[2:0], t_ff[11:10], data_ff[7:3],
                                     t_ff[4:0]};
                        toggle_in = 1'b0;
                     end
                  end
                  vrps_pkg::REG_ADDRESS: begin
                     if (!toggle_ff) begin
                        t_in      = {t_ff[15], 1'b0, data_ff[5:0], t_ff[7:0]};
                        toggle_in = 1'b1;
                     end else begin
                        t_in      = {t_ff[15:8], data_ff};
                        v_in      = {t_ff[15:8], data_ff};
                        toggle_in = 1'b0;
                     end
                  end
                  vrps_pkg::REG_DATA: begin
                     v_in = v_ff + step;
                  end
                  default: begin
                  end
               endcase
            end
            vrps_pkg::CMD_READ: begin
               if (reg_ff == vrps_pkg::REG_STATUS) begin
                  toggle_in = 1'b0;
                  rd_in     = status_ff;
                  status_in = {1'b0, status_ff[6:0]};
               end else if (reg_ff == vrps_pkg::REG_DATA) begin
                  v_in = v_ff + step;
               end
            end
            vrps_pkg::CMD_COARSE_X: begin
               if (rendering) begin
                  if (v_ff[4:0] == 5'd31) begin
                     v_in = {v_ff[15:11], !v_ff[10], v_ff[9:5], 5'd0};
                  end else begin
                     v_in = v_ff + 16'd1;
                  end
               end
            end
            vrps_pkg::CMD_INC_Y: begin
               if (rendering) begin
                  if (v_ff[14:12] != 3'd7) begin
                     v_in = v_ff + 16'h1000;
                  end else begin
                     v_in = {v_ff[15], 3'd0, v_ff[11] ^ y_flip, v_ff[10], coarse_y,
                             v_ff[4:0]};
                  end
               end
            end
            vrps_pkg::CMD_COPY_HORIZ: begin
               if (rendering) begin
                  v_in = {v_ff[15:11], t_ff[10], v_ff[9:5], t_ff[4:0]};
               end
            end
            vrps_pkg::CMD_COPY_VERT: begin
               if (rendering) begin
                  v_in = {v_ff[15], t_ff[14:11], v_ff[10], t_ff[9:5], v_ff[4:0]};
               end
            end
            vrps_pkg::CMD_VBLANK_SET: begin
               status_in = {1'b1, status_ff[6:0]};
               nmi_in    = control_ff[7];
            end
            vrps_pkg::CMD_PRERENDER: begin
               status_in = {3'b000, status_ff[4:0]};
            end
            default: begin
            end
         endcase
      end else if (cmd.load) begin
         buffer_in = fetched;
         rd_in     = high_ff ? fetched : buffer_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff    <= 8'd0;
         mask_ff       <= 8'd0;
         status_ff     <= 8'd0;
         sprite_ptr_ff <= 8'd0;
         v_ff          <= 16'd0;
         t_ff          <= 16'd0;
         fine_x_ff     <= 3'd0;
         toggle_ff     <= 1'b0;
         buffer_ff     <= 8'd0;
      end else begin
         control_ff    <= control_in;
         mask_ff       <= mask_in;
         status_ff     <= status_in;
         sprite_ptr_ff <= sprite_ptr_in;
         v_ff          <= v_in;
         t_ff          <= t_in;
         fine_x_ff     <= fine_x_in;
         toggle_ff     <= toggle_in;
         buffer_ff     <= buffer_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff  <= rd_in;
      nmi_ff <= nmi_in;
   end

   assign rsp_read_data     = rd_ff;
   assign rsp_nmi_pulse     = nmi_ff;
   assign rsp_vram_address  = v_ff;
   assign rsp_fine_scroll_x = fine_x_ff;

endmodule

/* rtl/vrps_checker.sv */
// ----------------------------------------------------------------------------
// Video register port checker
// Port-level checks of the start, busy and result strobe sequencing.
// ----------------------------------------------------------------------------
module vrps_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [7:0] rsp_read_data,
   input logic       rsp_nmi_pulse
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("Accepted word did not raise busy.");

   a_accept_no_strobe: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_valid)
      else $error("Result strobe in the cycle after acceptance.");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Result strobe lasted more than one cycle.");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("Result shown while busy.");

   a_nmi_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_nmi_pulse |-> rsp_read_data == 8'd0)
      else $error("Interrupt word carried read data.");

endmodule

bind video_register_port_scroll_unit vrps_checker u_vrps_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_read_data (rsp_read_data),
   .rsp_nmi_pulse (rsp_nmi_pulse)
);

/* bench/video_register_port_scroll_unit_tb.sv */
// ----------------------------------------------------------------------------
// Video register port and scroll unit testbench
// Drives bus register accesses and renderer events into the port and checks
// every result word against a predictor of the registers, the scroll logic
// and the name table and palette contents. The stimulus is a directed
// opening, mixed random bursts, and an address sweep by 32 from the upper
// name table area through the palette into the unmapped space above it.
// ----------------------------------------------------------------------------
module video_register_port_scroll_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vrps_pkg::*;

   localparam int QUIET_LIMIT = 1000;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        nmi_pulse;
      logic [15:0] vram_address;
      logic [2:0]  fine_scroll_x;
   } port_result_type;

   class port_scoreboard_type;
      logic [7:0]  ctrl_byte;
      logic [7:0]  mask_byte;
      logic [7:0]  status_byte;
      logic [7:0]  buffered_byte;
      logic [15:0] vaddr;
      logic [15:0] taddr;
      logic [2:0]  fine_x_pos;
      logic        second_write;
      logic [7:0]  vmem [4][TABLE_BYTES];
      bit          known [4][TABLE_BYTES];
      port_result_type due_results [$];
      int          errors;

      function new();
         ctrl_byte = '0;
         mask_byte = '0;
         status_byte = '0;
         buffered_byte = '0;
         vaddr = '0;
         taddr = '0;
         fine_x_pos = '0;
         second_write = 1'b0;
         errors = 0;
      endfunction

      function region_type locate(input logic [15:0] addr, output int unsigned slot);
         logic [15:0] folded;
         folded = addr & 16'h2FFF;
         slot = 0;
         if (addr >= 16'h2000 && addr < 16'h3F00) begin
            slot = 32'(folded[9:0]);
            return (folded < 16'h2400) ? RGN_TABLE_A : RGN_TABLE_B;
         end
         if (addr >= 16'h3F00 && addr <= 16'h3FFF) begin
            slot = 32'((addr[4] && addr[1:0] == 2'b00) ? {1'b0, addr[3:0]} : addr[4:0]);
            return RGN_PALETTE;
         end
         return RGN_NONE;
      endfunction

      function bit readable(input logic [15:0] addr);
         int unsigned slot;
         region_type rgn;
         rgn = locate(addr, slot);
         return rgn == RGN_NONE || known[int'(rgn)][slot];
      endfunction

      function logic [7:0] fetch(input logic [15:0] addr);
         int unsigned slot;
         region_type rgn;
         rgn = locate(addr, slot);
         if (rgn == RGN_NONE) return 8'h00;
         return vmem[int'(rgn)][slot];
      endfunction

      function void store(input logic [15:0] addr, input logic [7:0] data);
         int unsigned slot;
         region_type rgn;
         rgn = locate(addr, slot);
         if (rgn != RGN_NONE) begin
            vmem[int'(rgn)][slot] = data;
            known[int'(rgn)][slot] = 1'b1;
         end
      endfunction

      function void step_address();
         vaddr = vaddr + (ctrl_byte[2] ? 16'd32 : 16'd1);
      endfunction

      function void note_word(input cmd_type cmd, input logic [2:0] reg_no,
                              input logic [7:0] data);
         port_result_type due;
         logic [15:0] v;
         logic [15:0] t;
         logic [4:0]  coarse_y;
         bit          drawing;
         due = '0;
         v = vaddr;
         t = taddr;
         drawing = |mask_byte[4:3];
         case (cmd)
            CMD_WRITE: begin
               case (reg_no)
                  REG_CONTROL: begin
                     due.nmi_pulse = !ctrl_byte[7] && data[7] && status_byte[7];
                     ctrl_byte = data;
                     taddr = {t[15:12], data[1:0], t[9:0]};
                  end
                  REG_MASK: begin
                     mask_byte = data;
                  end
                  REG_SCROLL: begin
                     if (!second_write) begin
                        fine_x_pos = data[2:0];
                        taddr = {t[15:5], data[7:3]};
                     end else begin
                        taddr = {t[15], data[2:0], t[11:10], data[7:3], t[4:0]};
                     end
                     second_write = !second_write;
                  end
                  REG_ADDRESS: begin
                     if (!second_write) begin
                        taddr = {t[15], 1'b0, data[5:0], t[7:0]};
                     end else begin
                        taddr = {t[15:8], data};
                        vaddr = taddr;
                     end
                     second_write = !second_write;
                  end
                  REG_DATA: begin
                     store(v, data);
                     step_address();
                  end
                  default: begin
                  end
               endcase
            end
            CMD_READ: begin
               if (reg_no == REG_STATUS) begin
                  second_write = 1'b0;
                  due.read_data = status_byte;
                  status_byte[7] = 1'b0;
               end else if (reg_no == REG_DATA) begin
                  due.read_data = buffered_byte;
                  buffered_byte = fetch(v);
                  if (v >= 16'h3F00) due.read_data = buffered_byte;
                  step_address();
               end
            end
            CMD_COARSE_X: begin
               if (drawing) begin
                  vaddr = (v[4:0] == 5'd31) ? {v[15:11], ~v[10], v[9:5], 5'd0} : v + 16'd1;
               end
            end
            CMD_INC_Y: begin
               if (drawing) begin
                  if (v[14:12] != 3'd7) begin
                     vaddr = v + 16'h1000;
                  end else begin
                     v[14:12] = 3'd0;
                     coarse_y = v[9:5];
                     if (coarse_y == 5'd29) begin
                        coarse_y = 5'd0;
                        v[11] = ~v[11];
                     end else if (coarse_y == 5'd31) begin
                        coarse_y = 5'd0;
                     end else begin
                        coarse_y = coarse_y + 5'd1;
                     end
                     v[9:5] = coarse_y;
                     vaddr = v;
                  end
               end
            end
            CMD_COPY_HORIZ: begin
               if (drawing) vaddr = (v & ~16'h041F) | (t & 16'h041F);
            end
            CMD_COPY_VERT: begin
               if (drawing) vaddr = (v & ~16'h7BE0) | (t & 16'h7BE0);
            end
            CMD_VBLANK_SET: begin
               status_byte[7] = 1'b1;
               due.nmi_pulse = ctrl_byte[7];
            end
            default: begin
               status_byte = status_byte & 8'h1F;
            end
         endcase
         due.vram_address = vaddr;
         due.fine_scroll_x = fine_x_pos;
         due_results.push_back(due);
      endfunction

      task report_mismatch(input string what);
         errors++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_result(input logic [7:0] rd, input logic nmi, input logic [15:0] va,
                        input logic [2:0] fx);
         port_result_type want;
         if (due_results.size() == 0) begin
            report_mismatch($sformatf("result word with none pending, address %h", va));
            return;
         end
         want = due_results.pop_front();
         if (rd !== want.read_data)
            report_mismatch($sformatf("read_data %h, expected %h", rd, want.read_data));
         if (nmi !== want.nmi_pulse)
            report_mismatch($sformatf("nmi_pulse %b, expected %b", nmi, want.nmi_pulse));
         if (va !== want.vram_address)
            report_mismatch($sformatf("vram_address %h, expected %h", va, want.vram_address));
         if (fx !== want.fine_scroll_x)
            report_mismatch($sformatf("fine_scroll_x %h, expected %h", fx, want.fine_scroll_x));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_command;
   logic [2:0]  req_reg_index;
   logic [7:0]  req_write_data;
   logic        rsp_valid;
   logic [7:0]  rsp_read_data;
   logic        rsp_nmi_pulse;
   logic [15:0] rsp_vram_address;
   logic [2:0]  rsp_fine_scroll_x;

   port_scoreboard_type book;
   bit          idle_enable;
   int          words_sent;
   int          quiet_cycles;
   logic [13:0] last_fill = 14'h2000;

   video_register_port_scroll_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_reg_index     (req_reg_index),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_read_data     (rsp_read_data),
      .rsp_nmi_pulse     (rsp_nmi_pulse),
      .rsp_vram_address  (rsp_vram_address),
      .rsp_fine_scroll_x (rsp_fine_scroll_x)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         book.check_result(rsp_read_data, rsp_nmi_pulse, rsp_vram_address, rsp_fine_scroll_x);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic cmd_type any_cmd(input int unsigned lo, input int unsigned hi);
      logic [2:0] code;
      code = 3'($urandom_range(hi, lo));
      return cmd_type'(code);
   endfunction

   // A data read of a never-written table or palette entry is turned into a
   // write of that entry.
   task automatic send_word(input cmd_type cmd, input logic [2:0] reg_no,
                            input logic [7:0] data);
      if (cmd == CMD_READ && reg_no == REG_DATA && !book.readable(book.vaddr))
         cmd = CMD_WRITE;
      if (idle_enable && $urandom_range(99) < 21) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 21) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_reg_index <= reg_no;
      req_write_data <= data;
      do @(posedge clock); while (busy);
      book.note_word(cmd, reg_no, data);
      if (!(cmd == CMD_WRITE && reg_no == REG_STATUS)) words_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (book.due_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_address(input logic [13:0] addr);
      if (book.second_write) send_word(CMD_READ, REG_STATUS, 8'($urandom_range(255)));
      send_word(CMD_WRITE, REG_ADDRESS, {2'($urandom_range(3)), addr[13:8]});
      send_word(CMD_WRITE, REG_ADDRESS, addr[7:0]);
   endtask

   task automatic random_phase(input int quota);
      int         stop_at;
      int         pick;
      logic [7:0] data;
      logic [4:0] coarse_y;
      logic [2:0] fine_y;
      stop_at = words_sent + quota;
      while (words_sent < stop_at) begin
         pick = int'($urandom_range(19));
         if (pick < 5) begin
            case ($urandom_range(5))
               0, 1: last_fill = 14'h2000 + 14'($urandom_range(16'h0FFF));
               2: last_fill = 14'h3000 + 14'($urandom_range(16'h0EFF));
               3: last_fill = 14'h3F00 + 14'($urandom_range(8'hFF));
               4: last_fill = 14'($urandom_range(16'h1FFF));
               default: last_fill = 14'($urandom_range(16'h3FFF));
            endcase
            set_address(last_fill);
            repeat ($urandom_range(6, 1))
               send_word(CMD_WRITE, REG_DATA, 8'($urandom_range(255)));
         end else if (pick < 9) begin
            set_address(last_fill);
            repeat ($urandom_range(6, 1))
               send_word(CMD_READ, REG_DATA, 8'($urandom_range(255)));
         end else if (pick < 13) begin
            if ($urandom_range(1)) begin
               data = 8'($urandom_range(255));
               if ($urandom_range(4) != 0) data = data | ($urandom_range(1) ? 8'h08 : 8'h10);
               send_word(CMD_WRITE, REG_MASK, data);
            end
            if (book.second_write) send_word(CMD_READ, REG_STATUS, 8'($urandom_range(255)));
            send_word(CMD_WRITE, REG_SCROLL, 8'($urandom_range(255)));
            case ($urandom_range(3))
               0: coarse_y = 5'd29;
               1: coarse_y = 5'd31;
               2: coarse_y = 5'd30;
               default: coarse_y = 5'($urandom_range(31));
            endcase
            fine_y = $urandom_range(1) ? 3'd7 : 3'($urandom_range(7));
            send_word(CMD_WRITE, REG_SCROLL, {coarse_y, fine_y});
            send_word(CMD_COPY_VERT, 3'($urandom_range(7)), 8'($urandom_range(255)));
            send_word(CMD_COPY_HORIZ, 3'($urandom_range(7)), 8'($urandom_range(255)));
            repeat ($urandom_range(10, 3))
               send_word(any_cmd(2, 7), 3'($urandom_range(7)), 8'($urandom_range(255)));
         end else if (pick < 15) begin
            send_word(CMD_WRITE, REG_CONTROL, 8'($urandom_range(255)));
            if ($urandom_range(1))
               send_word(CMD_VBLANK_SET, 3'($urandom_range(7)), 8'($urandom_range(255)));
            send_word(CMD_WRITE, REG_CONTROL, 8'($urandom_range(255)));
            send_word(CMD_READ, REG_STATUS, 8'($urandom_range(255)));
         end else if (pick == 15) begin
            send_word(CMD_WRITE, REG_SPRITE_ADDR, 8'($urandom_range(255)));
            repeat ($urandom_range(4, 1))
               send_word(CMD_WRITE, REG_SPRITE_DATA, 8'($urandom_range(255)));
         end else if (pick < 18) begin
            send_word(any_cmd(0, 7), 3'($urandom_range(7)), 8'($urandom_range(255)));
         end else begin
            send_word(CMD_WRITE, $urandom_range(1) ? REG_ADDRESS : REG_SCROLL,
                      8'($urandom_range(255)));
            send_word(any_cmd(0, 7), 3'($urandom_range(7)), 8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      book = new();
      reset <= 1'b1;
      start <= 1'b0;
      req_command <= CMD_WRITE;
      req_reg_index <= REG_CONTROL;
      req_write_data <= 8'h00;
      idle_enable = 1'b1;
      words_sent = 0;
      quiet_cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_word(CMD_READ, REG_STATUS, 8'h00);
      send_word(CMD_WRITE, REG_CONTROL, 8'h80);
      send_word(CMD_VBLANK_SET, REG_CONTROL, 8'h00);
      send_word(CMD_WRITE, REG_CONTROL, 8'h00);
      send_word(CMD_WRITE, REG_CONTROL, 8'h83);
      send_word(CMD_READ, REG_STATUS, 8'hFF);
      send_word(CMD_PRERENDER, REG_DATA, 8'hFF);
      send_word(CMD_WRITE, REG_STATUS, 8'hFF);
      send_word(CMD_READ, REG_CONTROL, 8'h00);
      send_word(CMD_WRITE, REG_SPRITE_ADDR, 8'hFF);
      send_word(CMD_WRITE, REG_SPRITE_DATA, 8'h3C);
      send_word(CMD_WRITE, REG_ADDRESS, 8'h3F);
      send_word(CMD_WRITE, REG_ADDRESS, 8'h10);
      send_word(CMD_WRITE, REG_DATA, 8'hA5);
      send_word(CMD_WRITE, REG_ADDRESS, 8'hFF);
      send_word(CMD_WRITE, REG_ADDRESS, 8'h00);
      send_word(CMD_READ, REG_DATA, 8'h00);
      send_word(CMD_WRITE, REG_SCROLL, 8'hFF);
      send_word(CMD_WRITE, REG_SCROLL, 8'hEF);
      send_word(CMD_COARSE_X, REG_CONTROL, 8'h00);
      send_word(CMD_WRITE, REG_MASK, 8'h18);
      send_word(CMD_COPY_VERT, REG_CONTROL, 8'h00);
      send_word(CMD_INC_Y, REG_CONTROL, 8'h00);
      send_word(CMD_COPY_HORIZ, REG_CONTROL, 8'h00);
      send_word(CMD_COARSE_X, REG_CONTROL, 8'h00);
      send_word(CMD_WRITE, REG_MASK, 8'h00);
      drain();

      random_phase(180);
      drain();
      idle_enable = 1'b0;
      random_phase(120);
      idle_enable = 1'b1;
      drain();

      // Step by 32 from the upper name table area through the palette into
      // the unmapped space above it.
      send_word(CMD_WRITE, REG_CONTROL, 8'($urandom_range(255)) | 8'h04);
      set_address(14'h3E00);
      repeat (64)
         send_word($urandom_range(1) ? CMD_READ : CMD_WRITE, REG_DATA,
                   8'($urandom_range(255)));
      drain();

      random_phase(150);
      drain();
      repeat (8) @(posedge clock);
      if (book.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/vrps_pkg.sv
rtl/vrps_ctrl.sv
rtl/vrps_datapath.sv
rtl/video_register_port_scroll_unit.sv
rtl/vrps_checker.sv
bench/video_register_port_scroll_unit_tb.sv
